/* hdl/bounded_sequence_store_with_sort_core_macros.svh */
// assertion macros for the sequence store core
`ifndef BOUNDED_SEQUENCE_STORE_WITH_SORT_CORE_MACROS_SVH
`define BOUNDED_SEQUENCE_STORE_WITH_SORT_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define BSS_ASSERT_IMPL(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define BSS_ASSERT_NORST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BSS_ASSERT_IMPL(label, clk, rstn, prop, msg)
`define BSS_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

/* hdl/bss_pkg.sv */
// shared types and constants for the sequence store core
`default_nettype none
package bss_pkg;
    localparam int unsigned DEF_CAPACITY = 256;
    localparam int unsigned VAL_W = 32;

    typedef enum logic [2:0] {
        CMD_PUSH_BACK  = 3'd0,
        CMD_PUSH_FRONT = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_INSERT_AT  = 3'd4,
        CMD_REMOVE_AT  = 3'd5,
        CMD_READ_AT    = 3'd6,
        CMD_SORT       = 3'd7
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SH_RD,
        S_SH_WR,
        S_RD_WAIT,
        S_MG_SETUP,
        S_MG_RD,
        S_MG_WR,
        S_CP_RD,
        S_CP_WR,
        S_FR_RD,
        S_FR_WAIT,
        S_OUT
    } state_t;

    // datapath operation selectors
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LATCH,
        OP_SH_RD,
        OP_SH_WR,
        OP_FINISH_EDIT,
        OP_RD_ISSUE,
        OP_RD_TAKE,
        OP_SORT_INIT,
        OP_MG_SETUP,
        OP_MG_RD,
        OP_MG_WR,
        OP_CP_START,
        OP_CP_RD,
        OP_CP_WR,
        OP_PASS_END,
        OP_FR_RD,
        OP_FR_TAKE
    } op_t;

    typedef struct packed {
        op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic    edit_none;   // command changes no data
        logic    is_read;     // read_at that succeeds
        logic    is_sort;     // sort with two or more elements
        logic    shift_done;  // no more shift steps
        logic    merge_done;  // current run pair exhausted
        logic    pass_done;   // all run pairs of the pass merged
        logic    sort_done;   // run width covers whole store
        logic    copy_done;   // copy back finished
        logic    last_front;  // front read has been issued
    } dp_stat_t;
endpackage
`default_nettype wire

/* hdl/bounded_sequence_store_with_sort_core.sv */
// top level of the bounded sequence store with merge sort
// an edit without a shift and a failed command step through S_SH_RD, S_FR_RD, S_FR_WAIT, S_OUT;
//   read_at adds S_RD_WAIT, insert or remove an S_SH_RD/S_SH_WR pair per moved element,
//   sort its merge and copy passes; one transaction at a time, the state machine sets the pace
// reset: aresetn synchronous, active low; clears element count, order and control
// the element and scratch rams are not cleared and hold undefined data until written
`default_nettype none
`include "bounded_sequence_store_with_sort_core_macros.svh"
module bounded_sequence_store_with_sort_core
    import bss_pkg::*;
#(
    parameter int unsigned CAPACITY = DEF_CAPACITY
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // configuration: order_mode, 0 ascending, 1 descending
    input  wire logic         cfg_we,
    input  wire logic         cfg_wdata,
    // input stream
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [47:0]  s_tdata,   // command[2:0], position[10:3], value[42:11]
    // result stream
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [111:0]      m_tdata    // read_value[31:0], element_total[40:32],
                                         // is_empty[41], front_value[73:42],
                                         // back_value[105:74], status[107:106]
);
    logic      order_reg;
    dp_cmd_t   cmd;
    dp_stat_t  stat;
    logic      busy, out_load, in_fire, out_free;
    logic [VAL_W-1:0] rd_value, front_value, back_value;
    logic [8:0]       total;
    logic             empty;
    logic [1:0]       status;
    logic             m_valid_reg;
    logic [111:0]     m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            order_reg <= 1'b0;
        end else if (cfg_we) begin
            order_reg <= cfg_wdata;
        end
    end

    // accept a new transaction only when the engine is idle
    assign s_tready = !busy;
    assign in_fire  = s_tvalid && s_tready;
    // output register frees when empty or taken this cycle
    assign out_free = !m_valid_reg || m_tready;

    bss_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .in_fire(in_fire), .out_free(out_free),
        .stat(stat), .cmd(cmd), .busy(busy), .out_load(out_load)
    );

    bss_dp #(.CAPACITY(CAPACITY)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .order_mode(order_reg),
        .in_command(s_tdata[2:0]), .in_position(s_tdata[10:3]),
        .in_value(s_tdata[42:11]), .stat(stat), .rd_value(rd_value),
        .total(total), .empty(empty), .front_value(front_value),
        .back_value(back_value), .status(status)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= {4'd0, status, back_value, front_value,
                           empty, total, rd_value};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    `BSS_ASSERT_IMPL(a_no_accept_busy, aclk, aresetn, busy |-> !s_tready,
        "input accepted while busy")
    `BSS_ASSERT_IMPL(a_load_free, aclk, aresetn, out_load |-> out_free,
        "result loaded over an untaken result")
    `BSS_ASSERT_IMPL(a_load_valid, aclk, aresetn, out_load |=> m_tvalid,
        "loaded result not presented")
endmodule
`default_nettype wire

/* hdl/bss_ram.sv */
// generic single-port-write, single-port-read ram with registered read
`default_nettype none
module bss_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

/* hdl/bss_ctrl.sv */
// controller state machine for the sequence store core
`default_nettype none
module bss_ctrl
    import bss_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     in_fire,
    input  wire logic     out_free,
    input  dp_stat_t      stat,
    output dp_cmd_t       cmd,
    output logic          busy,
    output logic          out_load
);
    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        out_load   = 1'b0;
        busy       = (state_reg != S_IDLE);
        case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    cmd.op     = OP_LATCH;
                    state_next = S_SH_RD;
                end
            end
            S_SH_RD: begin
                // decide path from latched command
                if (stat.is_sort) begin
                    cmd.op     = OP_SORT_INIT;
                    state_next = S_MG_SETUP;
                end else if (stat.is_read) begin
                    cmd.op     = OP_RD_ISSUE;
                    state_next = S_RD_WAIT;
                end else if (stat.edit_none || stat.shift_done) begin
                    cmd.op     = OP_FINISH_EDIT;
                    state_next = S_FR_RD;
                end else begin
                    cmd.op     = OP_SH_RD;
                    state_next = S_SH_WR;
                end
            end
            S_SH_WR: begin
                cmd.op     = OP_SH_WR;
                state_next = S_SH_RD;
            end
            S_RD_WAIT: begin
                cmd.op     = OP_RD_TAKE;
                state_next = S_FR_RD;
            end
            S_MG_SETUP: begin
                if (stat.sort_done) begin
                    state_next = S_FR_RD;
                end else if (stat.pass_done) begin
                    cmd.op     = OP_CP_START;
                    state_next = S_CP_RD;
                end else begin
                    cmd.op     = OP_MG_SETUP;
                    state_next = S_MG_RD;
                end
            end
            S_MG_RD: begin
                if (stat.merge_done) begin
                    state_next = S_MG_SETUP;
                end else begin
                    cmd.op     = OP_MG_RD;
                    state_next = S_MG_WR;
                end
            end
            S_MG_WR: begin
                cmd.op     = OP_MG_WR;
                state_next = S_MG_RD;
            end
            S_CP_RD: begin
                if (stat.copy_done) begin
                    cmd.op     = OP_PASS_END;
                    state_next = S_MG_SETUP;
                end else begin
                    cmd.op     = OP_CP_RD;
                    state_next = S_CP_WR;
                end
            end
            S_CP_WR: begin
                cmd.op     = OP_CP_WR;
                state_next = S_CP_RD;
            end
            S_FR_RD: begin
                cmd.op = OP_FR_RD;
                if (stat.last_front) begin
                    state_next = S_FR_WAIT;
                end
            end
            S_FR_WAIT: begin
                cmd.op     = OP_FR_TAKE;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

/* hdl/bss_dp.sv */
// datapath of the sequence store core: counters, merge pointers, rams
`default_nettype none
module bss_dp
    import bss_pkg::*;
#(
    parameter int unsigned CAPACITY = DEF_CAPACITY
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  dp_cmd_t                    cmd,
    input  wire logic                  order_mode,
    input  wire logic [2:0]            in_command,
    input  wire logic [7:0]            in_position,
    input  wire logic [VAL_W-1:0]      in_value,
    output dp_stat_t                   stat,
    output logic [VAL_W-1:0]           rd_value,
    output logic [8:0]                 total,
    output logic                       empty,
    output logic [VAL_W-1:0]           front_value,
    output logic [VAL_W-1:0]           back_value,
    output logic [1:0]                 status
);
    localparam int unsigned AW = $clog2(CAPACITY);
    localparam int unsigned CW = AW + 1;     // holds CAPACITY itself
    localparam int unsigned RW = AW + 2;     // pointers that may pass count
    localparam int unsigned PW = (CW > 8) ? CW : 8;  // position compare width

    logic [CW-1:0]    count_reg;
    cmd_t             cmd_reg;
    logic [7:0]       pos_reg;
    logic [VAL_W-1:0] val_reg;
    status_t          status_reg;
    logic [VAL_W-1:0] rd_reg;
    logic [VAL_W-1:0] front_reg, back_reg;

    // shift walker
    logic [CW-1:0]    sh_idx_reg;    // destination index of next move
    logic [CW-1:0]    sh_end_reg;
    logic             sh_up_reg;     // insert moves upward

    // merge pointers
    logic [RW-1:0]    width_reg, lo_reg;
    logic [RW-1:0]    i_reg, j_reg, mid_reg, hi_reg, k_reg;
    logic [1:0]       fr_cnt_reg;

    // element ram (dual-read via two instances holding same data)
    logic             e_we;
    logic [AW-1:0]    e_waddr, e_raddr_a, e_raddr_b;
    logic [VAL_W-1:0] e_wdata, e_rdata_a, e_rdata_b;
    logic             s_we;
    logic [AW-1:0]    s_waddr, s_raddr;
    logic [VAL_W-1:0] s_wdata, s_rdata;

    bss_ram #(.WIDTH(VAL_W), .DEPTH(CAPACITY)) u_elem_a (
        .aclk(aclk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
        .raddr(e_raddr_a), .rdata(e_rdata_a)
    );
    bss_ram #(.WIDTH(VAL_W), .DEPTH(CAPACITY)) u_elem_b (
        .aclk(aclk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
        .raddr(e_raddr_b), .rdata(e_rdata_b)
    );
    bss_ram #(.WIDTH(VAL_W), .DEPTH(CAPACITY)) u_scratch (
        .aclk(aclk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
        .raddr(s_raddr), .rdata(s_rdata)
    );

    // command checks on latched item
    logic is_full, is_zero, ins_cmd, pop_cmd, pos_bad_ins, pos_bad_rd;
    logic ok_ins, ok_rem;
    logic [PW-1:0] pos_w, cnt_p;
    always_comb begin
        pos_w       = PW'(pos_reg);
        cnt_p       = PW'(count_reg);
        is_full     = (count_reg == CW'(CAPACITY));
        is_zero     = (count_reg == '0);
        ins_cmd     = (cmd_reg inside {CMD_PUSH_BACK, CMD_PUSH_FRONT, CMD_INSERT_AT});
        pop_cmd     = (cmd_reg inside {CMD_POP_FRONT, CMD_POP_BACK});
        pos_bad_ins = (pos_w > cnt_p);
        pos_bad_rd  = (pos_w >= cnt_p);
        ok_ins      = ins_cmd && !is_full && !((cmd_reg == CMD_INSERT_AT) && pos_bad_ins);
        ok_rem      = (pop_cmd && !is_zero) || ((cmd_reg == CMD_REMOVE_AT) && !pos_bad_rd);
    end

    // merge side choice: left run wins ties, so the sort stays stable
    logic keep_i, take_i;
    always_comb begin
        if (order_mode) begin
            keep_i = ($signed(e_rdata_a) >= $signed(e_rdata_b));
        end else begin
            keep_i = ($signed(e_rdata_a) <= $signed(e_rdata_b));
        end
        take_i = (i_reg < mid_reg) && ((j_reg >= hi_reg) || keep_i);
    end

    logic [RW-1:0] cnt_w, hi_full, mid_full, hi_cl, mid_cl;
    always_comb begin
        cnt_w    = RW'(count_reg);
        mid_full = lo_reg + width_reg;
        hi_full  = lo_reg + (width_reg << 1);
        mid_cl   = (mid_full > cnt_w) ? cnt_w : mid_full;
        hi_cl    = (hi_full > cnt_w) ? cnt_w : hi_full;
    end

    always_comb begin
        stat.edit_none  = !(ok_ins || ok_rem);
        stat.is_read    = (cmd_reg == CMD_READ_AT) && !pos_bad_rd;
        stat.is_sort    = (cmd_reg == CMD_SORT) && (count_reg > CW'(1));
        stat.shift_done = (sh_idx_reg == sh_end_reg);
        stat.merge_done = (k_reg >= hi_reg);
        stat.pass_done  = (lo_reg >= cnt_w);
        stat.sort_done  = (width_reg >= cnt_w);
        stat.copy_done  = (k_reg >= cnt_w);
        stat.last_front = (fr_cnt_reg == 2'd0);
    end

    // ram port steering
    always_comb begin
        e_we      = 1'b0;
        e_waddr   = sh_idx_reg[AW-1:0];
        e_wdata   = e_rdata_a;
        e_raddr_a = sh_idx_reg[AW-1:0];
        e_raddr_b = j_reg[AW-1:0];
        s_we      = 1'b0;
        s_waddr   = k_reg[AW-1:0];
        s_wdata   = take_i ? e_rdata_a : e_rdata_b;
        s_raddr   = k_reg[AW-1:0];
        case (cmd.op)
            OP_SH_RD: begin
                if (sh_up_reg) begin
                    e_raddr_a = AW'(sh_idx_reg - CW'(1));
                end else begin
                    e_raddr_a = AW'(sh_idx_reg + CW'(1));
                end
            end
            OP_SH_WR: begin
                e_we = 1'b1;
            end
            OP_FINISH_EDIT: begin
                e_we    = ok_ins;
                e_wdata = val_reg;
            end
            OP_RD_ISSUE: begin
                e_raddr_a = AW'(pos_reg);
            end
            OP_MG_RD: begin
                e_raddr_a = i_reg[AW-1:0];
                e_raddr_b = j_reg[AW-1:0];
            end
            OP_MG_WR: begin
                s_we = 1'b1;
            end
            OP_CP_WR: begin
                e_we    = 1'b1;
                e_waddr = k_reg[AW-1:0];
                e_wdata = s_rdata;
            end
            OP_FR_RD: begin
                e_raddr_a = '0;
                e_raddr_b = AW'(count_reg - CW'(1));
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            status_reg <= ST_OK;
        end else begin
            case (cmd.op)
                OP_LATCH: begin
                    cmd_reg    <= cmd_t'(in_command);
                    pos_reg    <= in_position;
                    val_reg    <= in_value;
                    rd_reg     <= '0;
                    status_reg <= ST_OK;
                    fr_cnt_reg <= 2'd1;
                    // walker: insert moves [pos..count-1] up, remove moves down
                    case (cmd_t'(in_command))
                        CMD_PUSH_BACK: begin
                            sh_up_reg  <= 1'b1;
                            sh_idx_reg <= count_reg;
                            sh_end_reg <= count_reg;
                        end
                        CMD_PUSH_FRONT: begin
                            sh_up_reg  <= 1'b1;
                            sh_idx_reg <= count_reg;
                            sh_end_reg <= '0;
                        end
                        CMD_INSERT_AT: begin
                            sh_up_reg  <= 1'b1;
                            sh_idx_reg <= count_reg;
                            sh_end_reg <= CW'(in_position);
                        end
                        CMD_POP_FRONT: begin
                            sh_up_reg  <= 1'b0;
                            sh_idx_reg <= '0;
                            sh_end_reg <= count_reg - CW'(1);
                        end
                        CMD_POP_BACK: begin
                            sh_up_reg  <= 1'b0;
                            sh_idx_reg <= count_reg - CW'(1);
                            sh_end_reg <= count_reg - CW'(1);
                        end
                        CMD_REMOVE_AT: begin
                            sh_up_reg  <= 1'b0;
                            sh_idx_reg <= CW'(in_position);
                            sh_end_reg <= count_reg - CW'(1);
                        end
                        default: begin
                            sh_up_reg  <= 1'b0;
                            sh_idx_reg <= '0;
                            sh_end_reg <= '0;
                        end
                    endcase
                end
                OP_SH_WR: begin
                    if (sh_up_reg) begin
                        sh_idx_reg <= sh_idx_reg - CW'(1);
                    end else begin
                        sh_idx_reg <= sh_idx_reg + CW'(1);
                    end
                end
                OP_FINISH_EDIT: begin
                    if (ok_ins) begin
                        count_reg <= count_reg + CW'(1);
                    end else if (ok_rem) begin
                        count_reg <= count_reg - CW'(1);
                    end else if (ins_cmd && is_full) begin
                        status_reg <= ST_FULL;
                    end else if (pop_cmd) begin
                        status_reg <= ST_EMPTY;
                    end else if (cmd_reg != CMD_SORT) begin
                        status_reg <= ST_RANGE;
                    end
                end
                OP_RD_TAKE: begin
                    rd_reg <= e_rdata_a;
                end
                OP_SORT_INIT: begin
                    width_reg <= RW'(1);
                    lo_reg    <= '0;
                end
                OP_MG_SETUP: begin
                    i_reg   <= lo_reg;
                    k_reg   <= lo_reg;
                    mid_reg <= mid_cl;
                    j_reg   <= mid_cl;
                    hi_reg  <= hi_cl;
                    lo_reg  <= hi_full;
                end
                OP_MG_WR: begin
                    k_reg <= k_reg + RW'(1);
                    if (take_i) begin
                        i_reg <= i_reg + RW'(1);
                    end else begin
                        j_reg <= j_reg + RW'(1);
                    end
                end
                OP_CP_START: begin
                    k_reg <= '0;
                end
                OP_CP_WR: begin
                    k_reg <= k_reg + RW'(1);
                end
                OP_PASS_END: begin
                    width_reg <= width_reg << 1;
                    lo_reg    <= '0;
                end
                OP_FR_RD: begin
                    fr_cnt_reg <= fr_cnt_reg - 2'd1;
                end
                OP_FR_TAKE: begin
                    front_reg <= is_zero ? '0 : e_rdata_a;
                    back_reg  <= is_zero ? '0 : e_rdata_b;
                end
                default: begin
                end
            endcase
        end
    end

    assign rd_value    = rd_reg;
    assign total       = 9'(count_reg);
    assign empty       = is_zero;
    assign front_value = front_reg;
    assign back_value  = back_reg;
    assign status      = status_reg;
endmodule
`default_nettype wire

/* dv/bounded_sequence_store_with_sort_core_tb.sv */
// testbench for the bounded sequence store core: directed and random commands, scoreboard check
`timescale 1ns / 100ps
module bounded_sequence_store_with_sort_core_tb;
    import bss_pkg::*;

    localparam int unsigned SLOTS = DEF_CAPACITY;
    // far beyond the slowest correct run: a few dozen full-store sorts plus stalls
    localparam int unsigned CYCLE_LIMIT = 20_000_000;

    typedef struct packed {
        logic [31:0] read_value;
        logic [8:0]  element_total;
        logic        is_empty;
        logic [31:0] front_value;
        logic [31:0] back_value;
        status_t     status;
    } seq_result_t;

    // mirror of the store: predicts the result of each accepted command
    class seq_scoreboard;
        int          cells[SLOTS];
        int unsigned count;
        bit          descending;
        seq_result_t awaited[$];
        int          errors;

        function bit stays_ahead(int a, int b);
            return descending ? (a >= b) : (a <= b);
        endfunction

        // stable insertion sort gives the same order as a stable merge sort
        function void sort_cells();
            int x;
            int j;
            for (int i = 1; i < count; i++) begin
                x = cells[i];
                j = i;
                while (j > 0 && !stays_ahead(cells[j-1], x)) begin
                    cells[j] = cells[j-1];
                    j--;
                end
                cells[j] = x;
            end
        endfunction

        function void put_cell(int unsigned at, int v);
            for (int unsigned i = count; i > at; i--) cells[i] = cells[i-1];
            cells[at] = v;
            count++;
        endfunction

        function void drop_cell(int unsigned at);
            for (int unsigned i = at; i + 1 < count; i++) cells[i] = cells[i+1];
            count--;
        endfunction

        function void note_command(cmd_t cmd, logic [7:0] pos, int v);
            seq_result_t r;
            r.status     = ST_OK;
            r.read_value = '0;
            case (cmd)
                CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
                    if (count >= SLOTS) r.status = ST_FULL;
                    else put_cell(cmd == CMD_PUSH_BACK ? count : 0, v);
                end
                CMD_POP_FRONT, CMD_POP_BACK: begin
                    if (count == 0) r.status = ST_EMPTY;
                    else drop_cell(cmd == CMD_POP_FRONT ? 0 : count - 1);
                end
                CMD_INSERT_AT: begin
                    if (count >= SLOTS) r.status = ST_FULL;
                    else if (pos > count) r.status = ST_RANGE;
                    else put_cell(pos, v);
                end
                CMD_REMOVE_AT: begin
                    if (pos >= count) r.status = ST_RANGE;
                    else drop_cell(pos);
                end
                CMD_READ_AT: begin
                    if (pos >= count) r.status = ST_RANGE;
                    else r.read_value = cells[pos];
                end
                default: begin
                    sort_cells();
                end
            endcase
            r.element_total = count[8:0];
            r.is_empty      = (count == 0);
            r.front_value   = count ? cells[0] : 0;
            r.back_value    = count ? cells[count-1] : 0;
            awaited.push_back(r);
        endfunction

        function void check_result(logic [111:0] d);
            seq_result_t e;
            if (awaited.size() == 0) begin
                $error("result transaction with nothing awaited: %h", d);
                errors++;
                return;
            end
            e = awaited.pop_front();
            if (d[31:0] !== e.read_value) begin
                $error("read_value expected %h actual %h", e.read_value, d[31:0]);
                errors++;
            end
            if (d[40:32] !== e.element_total) begin
                $error("element_total expected %0d actual %0d", e.element_total, d[40:32]);
                errors++;
            end
            if (d[41] !== e.is_empty) begin
                $error("is_empty expected %b actual %b", e.is_empty, d[41]);
                errors++;
            end
            if (d[73:42] !== e.front_value) begin
                $error("front_value expected %h actual %h", e.front_value, d[73:42]);
                errors++;
            end
            if (d[105:74] !== e.back_value) begin
                $error("back_value expected %h actual %h", e.back_value, d[105:74]);
                errors++;
            end
            if (d[107:106] !== e.status) begin
                $error("status expected %0d actual %0d", e.status, d[107:106]);
                errors++;
            end
        endfunction
    endclass

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_we = 1'b0;
    logic         cfg_wdata = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [47:0]  s_tdata = '0;   // command[2:0], position[10:3], value[42:11]
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [111:0] m_tdata;        // read_value, element_total, is_empty, front, back, status

    seq_scoreboard sb = new();
    bit            calm = 1'b0;   // no idling on either side while set
    bit            hold_req = 1'b0;
    int            hold_left = 0;
    int unsigned   cycles = 0;

    always #10 aclk = ~aclk;

    bounded_sequence_store_with_sort_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // result side: random back-pressure, plus one long hold-off when asked for
    always @(posedge aclk) begin
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = 600;
        end
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else begin
            m_tready <= calm || ($urandom_range(99) >= 29);
        end
    end

    // every accepted result transaction goes straight to the scoreboard
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    // watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // offer one command; returns once the transaction has been taken
    task automatic send_cmd(cmd_t cmd, logic [7:0] pos, int v);
        if (!calm && $urandom_range(99) < 29) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'd0, v, pos, cmd};
        do @(posedge aclk); while (!s_tready);
        sb.note_command(cmd, pos, v);
    endtask

    // only while idle: every result in, then a margin for the last command
    task automatic set_order(bit desc);
        s_tvalid <= 1'b0;
        while (sb.awaited.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= desc;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        sb.descending = desc;
    endtask

    function automatic int pick_value();
        case ($urandom_range(3))
            0: return $urandom_range(8) - 4;   // many equal values for the stable sort
            1: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [7:0] pick_pos();
        if ($urandom_range(9) == 0) return 8'($urandom_range(255));
        return 8'($urandom_range(sb.count > 255 ? 255 : sb.count));
    endfunction

    // random commands that keep the store size drifting around a target
    task automatic random_burst(int n, int unsigned target);
        int r;
        cmd_t c;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(99);
            if (sb.count < target) begin
                if (r < 25)      c = CMD_PUSH_BACK;
                else if (r < 40) c = CMD_PUSH_FRONT;
                else if (r < 55) c = CMD_INSERT_AT;
                else if (r < 62) c = CMD_POP_FRONT;
                else if (r < 68) c = CMD_POP_BACK;
                else if (r < 76) c = CMD_REMOVE_AT;
                else if (r < 95) c = CMD_READ_AT;
                else             c = CMD_SORT;
            end else begin
                if (r < 8)       c = CMD_PUSH_BACK;
                else if (r < 12) c = CMD_PUSH_FRONT;
                else if (r < 18) c = CMD_INSERT_AT;
                else if (r < 38) c = CMD_POP_FRONT;
                else if (r < 58) c = CMD_POP_BACK;
                else if (r < 80) c = CMD_REMOVE_AT;
                else if (r < 96) c = CMD_READ_AT;
                else             c = CMD_SORT;
            end
            send_cmd(c, pick_pos(), pick_value());
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        set_order(1'b0);

        // empty store: pops, out-of-range accesses and a sort that does nothing
        send_cmd(CMD_POP_FRONT, 8'd0, 0);
        send_cmd(CMD_POP_BACK, 8'd0, 0);
        send_cmd(CMD_REMOVE_AT, 8'd0, 0);
        send_cmd(CMD_READ_AT, 8'd0, 0);
        send_cmd(CMD_SORT, 8'd0, 0);
        send_cmd(CMD_INSERT_AT, 8'd1, 5);
        // one element sort, then edges of the value range
        send_cmd(CMD_PUSH_BACK, 8'd0, 32'h7fffffff);
        send_cmd(CMD_SORT, 8'd0, 0);
        send_cmd(CMD_PUSH_FRONT, 8'd255, 32'h80000000);
        send_cmd(CMD_READ_AT, 8'd1, 0);
        send_cmd(CMD_READ_AT, 8'd2, 0);
        send_cmd(CMD_INSERT_AT, 8'd3, 1);
        send_cmd(CMD_INSERT_AT, 8'd2, -1);    // position equal to count appends
        send_cmd(CMD_INSERT_AT, 8'd0, 0);
        send_cmd(CMD_PUSH_BACK, 8'd0, -1);
        send_cmd(CMD_SORT, 8'd0, 0);
        send_cmd(CMD_READ_AT, 8'd255, 0);
        send_cmd(CMD_REMOVE_AT, 8'd1, 0);
        send_cmd(CMD_REMOVE_AT, 8'd4, 0);
        send_cmd(CMD_POP_FRONT, 8'd0, 0);
        send_cmd(CMD_POP_BACK, 8'd0, 0);

        // fill to capacity, then full-store rejections and a full sort
        while (sb.count < SLOTS) send_cmd(CMD_PUSH_BACK, 8'd0, pick_value());
        send_cmd(CMD_PUSH_BACK, 8'd0, 7);
        send_cmd(CMD_PUSH_FRONT, 8'd0, 7);
        send_cmd(CMD_INSERT_AT, 8'd255, 7);   // full wins over position
        send_cmd(CMD_READ_AT, 8'd255, 0);
        send_cmd(CMD_SORT, 8'd0, 0);
        send_cmd(CMD_REMOVE_AT, 8'd255, 0);
        send_cmd(CMD_INSERT_AT, 8'd255, -7);

        set_order(1'b1);
        send_cmd(CMD_SORT, 8'd0, 0);          // descending sort of a full store
        random_burst(120, 8);

        // long hold-off on the result side while commands keep coming
        hold_req = 1'b1;
        random_burst(60, 16);

        set_order(1'b0);
        calm = 1'b1;
        random_burst(100, 24);
        calm = 1'b0;
        random_burst(120, 40);

        set_order(1'b1);
        random_burst(96, 12);
        random_burst(70, 64);

        s_tvalid <= 1'b0;
        while (sb.awaited.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (sb.errors == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end
endmodule
